### hw/rtl/srsg_pkg.sv
// Shared widths, register indexes, reset values and fixed-point constants
// for the stepper ramp step generator. No dependencies.
package srsg_pkg;

	// Field widths of the item and result beats.
	localparam int SPEED_W   = 24;
	localparam int ELAPSED_W = 16;

	// Configuration registers.
	localparam int ACCEL_W    = 20;
	localparam int THRESH_W   = 16;
	localparam int CFG_DATA_W = 20;
	localparam int CFG_IDX_W  = 1;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_ACCEL      = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STOP_THRESHOLD = 1'd1;

	localparam logic [ACCEL_W-1:0]  MAX_ACCEL_RST      = 20'd4000;
	localparam logic [THRESH_W-1:0] STOP_THRESHOLD_RST = 16'd256;

	// One second in microseconds, and the saturation points of the ramp math.
	localparam int               US_W          = 20;
	localparam logic [US_W-1:0]  US_PER_SECOND = 20'd1000000;
	localparam int PRODUCT_CAP_LOG2 = 40;
	localparam int DELTA_CAP_LOG2   = 25;
	localparam int DELTA_W          = DELTA_CAP_LOG2 + 1;

	// Defaults for the top-level parameters.
	localparam int DEF_SPEED_FRAC_BITS = 8;
	localparam int DEF_TIME_WIDTH      = 32;

endpackage

### hw/rtl/stepper_ramp_step_generator.sv
// Top level of the stepper ramp step generator: handshakes, configuration
// registers, motion state and the sequencer. Depends on srsg_pkg,
// srsg_ramp_delta and srsg_step_test.
//
// One item is worked on at a time. A disabled item, or one with no elapsed
// time since the last ramp, goes from ST_PREP straight to ST_FINISH. An item
// that ramps the speed passes through the bit-serial accel * dt multiplier,
// the restoring divider by one million and, unless the new speed falls below
// the stop threshold, the serial step-interval multiplier. The result sits in
// an output register, so the next item is taken while a result beat still
// waits for out_ready; that item then waits in ST_FINISH until the beat is
// taken.
module stepper_ramp_step_generator #(
	parameter int SPEED_FRAC_BITS = srsg_pkg::DEF_SPEED_FRAC_BITS,
	parameter int TIME_WIDTH      = srsg_pkg::DEF_TIME_WIDTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Configuration write port.
	input  logic                              cfg_wr_en,
	input  logic [srsg_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [srsg_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	// Item channel.
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [srsg_pkg::ELAPSED_W-1:0]    elapsed_us,
	input  logic signed [srsg_pkg::SPEED_W-1:0] target_speed,
	input  logic                              enable_level,
	input  logic                              stop_now,
	// Result channel.
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              step_pulse,
	output logic                              dir_forward,
	output logic                              driver_enable_n,
	output logic signed [srsg_pkg::SPEED_W-1:0] speed_now
);
	import srsg_pkg::*;

	localparam int RAMP_W = DELTA_W + 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_RAMP,
		ST_CHECK,
		ST_STEP,
		ST_FINISH
	} state_t;

	state_t                     state_q;
	logic [ACCEL_W-1:0]         max_accel_q;
	logic [THRESH_W-1:0]        stop_thr_q;
	logic signed [SPEED_W-1:0]  speed_q;
	logic signed [SPEED_W-1:0]  tgt_q;
	logic                       en_q;
	logic                       stop_q;
	logic [TIME_WIDTH-1:0]      since_upd_q;
	logic [TIME_WIDTH-1:0]      since_step_q;
	logic                       dir_q;
	logic                       is_en_q;
	logic                       step_q;
	logic                       out_valid_q;
	logic                       step_pulse_q;
	logic                       dir_forward_q;
	logic                       driver_enable_n_q;
	logic signed [SPEED_W-1:0]  speed_now_q;

	logic [TIME_WIDTH:0]        upd_sum;
	logic [TIME_WIDTH-1:0]      upd_sat;
	logic [TIME_WIDTH:0]        stp_sum;
	logic [TIME_WIDTH-1:0]      stp_sat;
	logic                       ramp_start;
	logic                       ramp_done;
	logic [DELTA_W-1:0]         ramp_delta;
	logic                       step_start;
	logic                       step_done;
	logic                       step_hit;
	logic signed [RAMP_W-1:0]   cur_x;
	logic signed [RAMP_W-1:0]   tgt_x;
	logic signed [RAMP_W-1:0]   dlt_x;
	logic signed [RAMP_W-1:0]   ramp_sum;
	logic signed [SPEED_W-1:0]  ramp_speed;
	logic [SPEED_W-1:0]         mag;
	logic                       below;
	logic                       out_free;

	// Saturating timers.
	assign upd_sum = {1'b0, since_upd_q} + (TIME_WIDTH + 1)'(elapsed_us);
	assign upd_sat = upd_sum[TIME_WIDTH] ? '1 : upd_sum[TIME_WIDTH-1:0];
	assign stp_sum = {1'b0, since_step_q} + (TIME_WIDTH + 1)'(elapsed_us);
	assign stp_sat = stp_sum[TIME_WIDTH] ? '1 : stp_sum[TIME_WIDTH-1:0];

	// Ramp toward the target by at most one delta, never passing it.
	always_comb begin
		cur_x = RAMP_W'(speed_q);
		tgt_x = RAMP_W'(tgt_q);
		dlt_x = signed'(RAMP_W'(ramp_delta));
		if (tgt_x > cur_x) begin
			ramp_sum = cur_x + dlt_x;
			if (ramp_sum > tgt_x) begin
				ramp_sum = tgt_x;
			end
		end else if (tgt_x < cur_x) begin
			ramp_sum = cur_x - dlt_x;
			if (ramp_sum < tgt_x) begin
				ramp_sum = tgt_x;
			end
		end else begin
			ramp_sum = cur_x;
		end
	end
	assign ramp_speed = signed'(ramp_sum[SPEED_W-1:0]);

	// Magnitude and stop region.
	assign mag   = speed_q[SPEED_W-1] ? unsigned'(-speed_q) : unsigned'(speed_q);
	assign below = mag < SPEED_W'(stop_thr_q);

	assign ramp_start = (state_q == ST_PREP) && en_q && (since_upd_q != '0);
	assign step_start = (state_q == ST_CHECK) && !below;
	assign out_free   = !out_valid_q || out_ready;

	srsg_ramp_delta #(
		.TIME_WIDTH      (TIME_WIDTH),
		.SPEED_FRAC_BITS (SPEED_FRAC_BITS)
	) u_ramp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ramp_start),
		.dt     (since_upd_q),
		.accel  (max_accel_q),
		.done   (ramp_done),
		.delta  (ramp_delta)
	);

	srsg_step_test #(
		.TIME_WIDTH      (TIME_WIDTH),
		.SPEED_FRAC_BITS (SPEED_FRAC_BITS)
	) u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (step_start),
		.since  (since_step_q),
		.mag    (mag),
		.done   (step_done),
		.hit    (step_hit)
	);

	// Sequencer, motion state, configuration and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= ST_IDLE;
			max_accel_q       <= MAX_ACCEL_RST;
			stop_thr_q        <= STOP_THRESHOLD_RST;
			speed_q           <= '0;
			tgt_q             <= '0;
			en_q              <= 1'b0;
			stop_q            <= 1'b0;
			since_upd_q       <= '0;
			since_step_q      <= '0;
			dir_q             <= 1'b1;
			is_en_q           <= 1'b0;
			step_q            <= 1'b0;
			out_valid_q       <= 1'b0;
			step_pulse_q      <= 1'b0;
			dir_forward_q     <= 1'b1;
			driver_enable_n_q <= 1'b1;
			speed_now_q       <= '0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_MAX_ACCEL:      max_accel_q <= cfg_wdata[ACCEL_W-1:0];
					REG_STOP_THRESHOLD: stop_thr_q  <= cfg_wdata[THRESH_W-1:0];
					default: ;
				endcase
			end

			// A taken beat empties the result register unless the next one loads it.
			if (out_valid_q && out_ready && (state_q != ST_FINISH)) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						tgt_q        <= target_speed;
						en_q         <= enable_level;
						stop_q       <= stop_now;
						since_upd_q  <= upd_sat;
						since_step_q <= stp_sat;
						step_q       <= 1'b0;
						state_q      <= ST_PREP;
					end
				end
				ST_PREP: begin
					if (!en_q) begin
						is_en_q <= 1'b0;
						speed_q <= '0;
						state_q <= ST_FINISH;
					end else begin
						is_en_q <= 1'b1;
						if (stop_q) begin
							speed_q <= '0;
							tgt_q   <= '0;
						end
						if (since_upd_q == '0) begin
							state_q <= ST_FINISH;
						end else begin
							since_upd_q <= '0;
							state_q     <= ST_RAMP;
						end
					end
				end
				ST_RAMP: begin
					if (ramp_done) begin
						speed_q <= ramp_speed;
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (below) begin
						speed_q <= '0;
						state_q <= ST_FINISH;
					end else begin
						dir_q   <= !speed_q[SPEED_W-1] && (speed_q != '0);
						state_q <= ST_STEP;
					end
				end
				ST_STEP: begin
					if (step_done) begin
						if (step_hit) begin
							step_q       <= 1'b1;
							since_step_q <= '0;
						end
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						out_valid_q       <= 1'b1;
						step_pulse_q      <= step_q;
						dir_forward_q     <= dir_q;
						driver_enable_n_q <= !is_en_q;
						speed_now_q       <= speed_q;
						state_q           <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready        = (state_q == ST_IDLE);
	assign out_valid       = out_valid_q;
	assign step_pulse      = step_pulse_q;
	assign dir_forward     = dir_forward_q;
	assign driver_enable_n = driver_enable_n_q;
	assign speed_now       = speed_now_q;

	// A step beat only comes from an enabled, moving motor.
	a_step_needs_enable: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && step_pulse) |-> !driver_enable_n)
		else $error("step beat while drivers disabled");

	a_step_needs_speed: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && step_pulse) |-> (speed_now != '0))
		else $error("step beat at zero speed");

	// Disabled beats always report a cleared speed.
	a_disabled_zero_speed: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && driver_enable_n) |-> (speed_now == '0))
		else $error("disabled beat with nonzero speed");

	// Only one item is in work at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second item accepted while one is in work");

endmodule

### hw/rtl/srsg_ramp_delta.sv
// Bit-serial ramp step unit: max_accel * dt by shift-and-add, capped, then
// divided by one million with a restoring divider, one bit per cycle.
// Depends on srsg_pkg.
module srsg_ramp_delta #(
	parameter int TIME_WIDTH      = srsg_pkg::DEF_TIME_WIDTH,
	parameter int SPEED_FRAC_BITS = srsg_pkg::DEF_SPEED_FRAC_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [TIME_WIDTH-1:0]        dt,
	input  logic [srsg_pkg::ACCEL_W-1:0] accel,
	output logic                         done,
	output logic [srsg_pkg::DELTA_W-1:0] delta
);
	import srsg_pkg::*;

	localparam int PROD_W   = ACCEL_W + TIME_WIDTH;
	localparam int CAPPED_W = PRODUCT_CAP_LOG2 + 1;
	localparam int PEXT_W   = (PROD_W > CAPPED_W) ? PROD_W : CAPPED_W;
	localparam int DIVN     = CAPPED_W + SPEED_FRAC_BITS;
	localparam int CNT_MAX  = (DIVN > TIME_WIDTH) ? DIVN : TIME_WIDTH;
	localparam int CNT_W    = $clog2(CNT_MAX + 1);

	localparam logic [PEXT_W-1:0]  PRODUCT_CAP = PEXT_W'(1) << PRODUCT_CAP_LOG2;
	localparam logic [DELTA_W-1:0] DELTA_CAP   = DELTA_W'(1) << DELTA_CAP_LOG2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_CAP,
		ST_DIV
	} state_t;

	state_t               state_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [ACCEL_W-1:0]   accel_q;
	logic [ACCEL_W-1:0]   acc_q;
	logic [TIME_WIDTH-1:0] mlr_q;
	logic [DIVN-1:0]      div_q;
	logic [US_W-1:0]      rem_q;
	logic [DELTA_W-1:0]   quo_q;
	logic                 ovf_q;
	logic                 done_q;
	logic [DELTA_W-1:0]   delta_q;

	logic [ACCEL_W:0]     mul_sum;
	logic [PEXT_W-1:0]    prod_ext;
	logic [CAPPED_W-1:0]  prod_capped;
	logic [US_W:0]        div_trial;
	logic                 div_ge;
	logic [US_W-1:0]      div_rem;
	logic [DELTA_W-1:0]   quo_next;
	logic                 ovf_next;
	logic [DELTA_W-1:0]   delta_final;

	// Shift-and-add multiplier step: the low product bits shift into the
	// multiplier register as its bits are used up.
	assign mul_sum = {1'b0, acc_q} + (mlr_q[0] ? {1'b0, accel_q} : '0);

	// Product cap at 2^40.
	assign prod_ext    = PEXT_W'({acc_q, mlr_q});
	assign prod_capped = (prod_ext > PRODUCT_CAP) ? CAPPED_W'(PRODUCT_CAP)
		: prod_ext[CAPPED_W-1:0];

	// Restoring division by one million, dividend fed MSB first.
	assign div_trial = {rem_q, div_q[DIVN-1]};
	assign div_ge    = div_trial >= {1'b0, US_PER_SECOND};
	assign div_rem   = div_ge ? US_W'(div_trial - {1'b0, US_PER_SECOND})
		: div_trial[US_W-1:0];

	// Quotient bits above the cap are folded into a sticky overflow flag.
	assign quo_next    = {quo_q[DELTA_W-2:0], div_ge};
	assign ovf_next    = ovf_q | quo_q[DELTA_W-1];
	assign delta_final = (ovf_next || (quo_next[DELTA_W-1] && |quo_next[DELTA_W-2:0]))
		? DELTA_CAP : quo_next;

	// Sequencer and datapath registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			accel_q <= '0;
			acc_q   <= '0;
			mlr_q   <= '0;
			div_q   <= '0;
			rem_q   <= '0;
			quo_q   <= '0;
			ovf_q   <= 1'b0;
			done_q  <= 1'b0;
			delta_q <= '0;
		end else begin
			done_q <= (state_q == ST_DIV) && (cnt_q == '0);
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						accel_q <= accel;
						mlr_q   <= dt;
						acc_q   <= '0;
						cnt_q   <= CNT_W'(TIME_WIDTH - 1);
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					acc_q <= mul_sum[ACCEL_W:1];
					mlr_q <= {mul_sum[0], mlr_q[TIME_WIDTH-1:1]};
					if (cnt_q == '0) begin
						state_q <= ST_CAP;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_CAP: begin
					div_q   <= DIVN'(prod_capped) << SPEED_FRAC_BITS;
					rem_q   <= '0;
					quo_q   <= '0;
					ovf_q   <= 1'b0;
					cnt_q   <= CNT_W'(DIVN - 1);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					div_q <= div_q << 1;
					rem_q <= div_rem;
					quo_q <= quo_next;
					ovf_q <= ovf_next;
					if (cnt_q == '0) begin
						delta_q <= delta_final;
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done  = done_q;
	assign delta = delta_q;

endmodule

### hw/rtl/srsg_step_test.sv
// Bit-serial step test: (since_step + 1) * |speed| against one million
// scaled by 2^SPEED_FRAC_BITS, low bits compared LSB first as they appear.
// Depends on srsg_pkg.
module srsg_step_test #(
	parameter int TIME_WIDTH      = srsg_pkg::DEF_TIME_WIDTH,
	parameter int SPEED_FRAC_BITS = srsg_pkg::DEF_SPEED_FRAC_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [TIME_WIDTH-1:0]        since,
	input  logic [srsg_pkg::SPEED_W-1:0] mag,
	output logic                         done,
	output logic                         hit
);
	import srsg_pkg::*;

	localparam int OPA_W = TIME_WIDTH + 1;
	localparam int CNT_W = $clog2(SPEED_W);

	localparam logic [63:0] LIMIT    = 64'(US_PER_SECOND) << SPEED_FRAC_BITS;
	localparam logic [63:0] LIMIT_HI = LIMIT >> SPEED_W;

	typedef enum logic {
		ST_IDLE,
		ST_MUL
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [OPA_W-1:0]   opa_q;
	logic [OPA_W-1:0]   acc_q;
	logic [SPEED_W-1:0] mlr_q;
	logic [SPEED_W-1:0] lim_q;
	logic               gt_q;
	logic               done_q;
	logic               hit_q;

	logic [OPA_W:0]     sum;
	logic [OPA_W-1:0]   acc_next;
	logic               gt_next;
	logic               hit_final;

	// One partial product per cycle; the bit that drops out is final.
	assign sum      = {1'b0, acc_q} + (mlr_q[0] ? {1'b0, opa_q} : '0);
	assign acc_next = sum[OPA_W:1];

	// Serial magnitude compare of the low product bits, LSB first.
	assign gt_next = (sum[0] & ~lim_q[0]) | (~(sum[0] ^ lim_q[0]) & gt_q);

	// The upper product half decides unless it ties with the limit.
	assign hit_final = (64'(acc_next) > LIMIT_HI)
		|| ((64'(acc_next) == LIMIT_HI) && gt_next);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			opa_q   <= '0;
			acc_q   <= '0;
			mlr_q   <= '0;
			lim_q   <= '0;
			gt_q    <= 1'b0;
			done_q  <= 1'b0;
			hit_q   <= 1'b0;
		end else begin
			done_q <= (state_q == ST_MUL) && (cnt_q == '0);
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						opa_q   <= OPA_W'(since) + OPA_W'(1);
						acc_q   <= '0;
						mlr_q   <= mag;
						lim_q   <= LIMIT[SPEED_W-1:0];
						gt_q    <= 1'b0;
						cnt_q   <= CNT_W'(SPEED_W - 1);
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					acc_q <= acc_next;
					mlr_q <= mlr_q >> 1;
					lim_q <= lim_q >> 1;
					gt_q  <= gt_next;
					if (cnt_q == '0) begin
						hit_q   <= hit_final;
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done = done_q;
	assign hit  = hit_q;

endmodule
